// ===== design/thdc_pkg.sv =====
// Shared types and constants for the touch hold duration classifier.
// No dependencies; every design file imports this package.
package thdc_pkg;

    // Field and state widths
    localparam int TICK_W  = 10;
    localparam int THR_W   = 16;
    localparam int HELD_W  = 24;
    localparam int LEVEL_W = 8;

    // Loading bar scaling
    localparam int LED_COUNT   = 16;
    localparam int MS_PER_S    = 1000;
    localparam int RED_EXTRA   = 4;
    localparam int GREEN_EXTRA = 1;
    localparam int RED_K       = LED_COUNT + RED_EXTRA;
    localparam int GREEN_K     = LED_COUNT + GREEN_EXTRA;
    localparam int K_W         = $clog2(RED_K + 1);
    localparam int PROD_W      = HELD_W + K_W;

    // Saturation and divide-by-1000 through a reciprocal multiply
    localparam int LEVEL_MAX = (1 << LEVEL_W) - 1;
    localparam int SAT_LIMIT = (LEVEL_MAX + 1) * MS_PER_S;
    localparam int SAT_W     = $clog2(SAT_LIMIT);
    localparam int DIV_SHIFT = 28;
    localparam int DIV_M     = ((1 << DIV_SHIFT) + MS_PER_S - 1) / MS_PER_S;
    localparam int DIV_M_W   = $clog2(DIV_M + 1);
    localparam int QMUL_W    = SAT_W + DIV_M_W;

    // Register port
    localparam int ADDR_W = 4;
    localparam int DATA_W = 32;

    localparam logic [TICK_W-1:0] TICK_RST     = TICK_W'(100);
    localparam logic [THR_W-1:0]  PLAY_RST     = THR_W'(500);
    localparam logic [THR_W-1:0]  NEXT_RST     = THR_W'(1500);
    localparam logic [THR_W-1:0]  POWER_RST    = THR_W'(3000);

    typedef enum logic [1:0] {
        REG_TICK       = 2'd0,
        REG_PLAY_PAUSE = 2'd1,
        REG_NEXT       = 2'd2,
        REG_POWER_OFF  = 2'd3
    } reg_idx_t;

    typedef enum logic [2:0] {
        ACT_NONE       = 3'd0,
        ACT_PLAY_PAUSE = 3'd1,
        ACT_NEXT       = 3'd2,
        ACT_POWER_OFF  = 3'd3,
        ACT_CLEAR      = 3'd4
    } action_t;

    typedef enum logic [1:0] {
        LED_NONE   = 2'd0,
        LED_YELLOW = 2'd1,
        LED_GREEN  = 2'd2,
        LED_RED    = 2'd3
    } led_mode_t;

    typedef struct packed {
        logic [TICK_W-1:0] tick_ms;
        logic [THR_W-1:0]  play_pause_ms;
        logic [THR_W-1:0]  next_ms;
        logic [THR_W-1:0]  power_off_ms;
    } cfg_t;

    // Result of the hold tracker, waiting for the bar level
    typedef struct packed {
        action_t           action;
        led_mode_t         mode;
        logic              red;
        logic [HELD_W-1:0] diff;
    } track_t;

    // Scaled bar product, waiting for the divide
    typedef struct packed {
        action_t           action;
        led_mode_t         mode;
        logic [PROD_W-1:0] prod;
    } scaled_t;

endpackage

// ===== design/touch_hold_duration_classifier.sv =====
// Top level of the touch hold duration classifier.
// Depends on thdc_pkg, thdc_cfg_regs, thdc_hold_tracker and thdc_bar_level.
//
// Usage:
//   Input channel (in_valid/in_ready, pad_touched): one transaction per
//   sampling tick, telling whether the pad fired during that tick.
//   Output channel (out_valid/out_ready, action, led_mode, led_level):
//   exactly one transaction per input tick, in order. During a hold the
//   result carries the loading bar mode and level; on release it carries
//   the action chosen by the zones reached (power off over next over
//   play/pause, else clear display if anything was held).
//   Configuration: APB-style port, tick_ms at 0x0, play_pause_ms at 0x4,
//   next_ms at 0x8, power_off_ms at 0xC. pready is tied high; write only
//   while no tick is in flight.
// Timing:
//   Three register stages: hold tracker, bar scaling multiply, divide and
//   saturate. One tick is taken every cycle while the output is not
//   stalled; the hold state updates at acceptance, so consecutive ticks
//   chain through the tracker register with no gap.
// Reset: hold time, grace and zone flags clear, registers return to their
//   defaults (100, 500, 1500, 3000 ms), and the pipeline empties.
// Stall: each stage holds its transaction while the next is full; bubbles
//   ahead of a stalled output still fill, then in_ready drops.
module touch_hold_duration_classifier
    import thdc_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    // configuration port
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [ADDR_W-1:0]  paddr,
    input  logic [DATA_W-1:0]  pwdata,
    output logic [DATA_W-1:0]  prdata,
    output logic               pready,
    // tick input
    input  logic               in_valid,
    output logic               in_ready,
    input  logic               pad_touched,
    // result output
    output logic               out_valid,
    input  logic               out_ready,
    output logic [2:0]         action,
    output logic [1:0]         led_mode,
    output logic [LEVEL_W-1:0] led_level
);

    cfg_t   cfg;
    logic   trk_valid;
    logic   trk_ready;
    track_t trk;

    // Register writes complete in the access phase, never wait
    assign pready = 1'b1;

    thdc_cfg_regs u_cfg_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .cfg     (cfg)
    );

    // Advance hold time and zone flags; pick the release action
    thdc_hold_tracker u_hold_tracker (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg         (cfg),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .pad_touched (pad_touched),
        .trk_valid   (trk_valid),
        .trk_ready   (trk_ready),
        .trk         (trk)
    );

    // Turn the held time past the zone base into a lit LED count
    thdc_bar_level u_bar_level (
        .clk       (clk),
        .rst_n     (rst_n),
        .trk_valid (trk_valid),
        .trk_ready (trk_ready),
        .trk       (trk),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .action    (action),
        .led_mode  (led_mode),
        .led_level (led_level)
    );

endmodule

// ===== design/thdc_cfg_regs.sv =====
// Configuration register file behind the APB-style port.
// Depends on thdc_pkg.
module thdc_cfg_regs
    import thdc_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [DATA_W-1:0] pwdata,
    output logic [DATA_W-1:0] prdata,
    output cfg_t              cfg
);

    cfg_t     cfg_reg;
    cfg_t     cfg_next;
    reg_idx_t idx;
    logic     wr_en;

    assign idx   = reg_idx_t'(paddr[ADDR_W-1:2]);
    assign wr_en = psel && penable && pwrite;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            case (idx)
                REG_TICK:       cfg_next.tick_ms       = pwdata[TICK_W-1:0];
                REG_PLAY_PAUSE: cfg_next.play_pause_ms = pwdata[THR_W-1:0];
                REG_NEXT:       cfg_next.next_ms       = pwdata[THR_W-1:0];
                REG_POWER_OFF:  cfg_next.power_off_ms  = pwdata[THR_W-1:0];
                default:        cfg_next = cfg_reg;
            endcase
        end
    end

    always_comb
    begin
        case (idx)
            REG_TICK:       prdata = DATA_W'(cfg_reg.tick_ms);
            REG_PLAY_PAUSE: prdata = DATA_W'(cfg_reg.play_pause_ms);
            REG_NEXT:       prdata = DATA_W'(cfg_reg.next_ms);
            REG_POWER_OFF:  prdata = DATA_W'(cfg_reg.power_off_ms);
            default:        prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.tick_ms       <= TICK_RST;
            cfg_reg.play_pause_ms <= PLAY_RST;
            cfg_reg.next_ms       <= NEXT_RST;
            cfg_reg.power_off_ms  <= POWER_RST;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

// ===== design/thdc_hold_tracker.sv =====
// Hold state, zone classification and release action for one tick.
// Depends on thdc_pkg; feeds thdc_bar_level.
module thdc_hold_tracker
    import thdc_pkg::*;
(
    input  logic   clk,
    input  logic   rst_n,
    input  cfg_t   cfg,
    input  logic   in_valid,
    output logic   in_ready,
    input  logic   pad_touched,
    output logic   trk_valid,
    input  logic   trk_ready,
    output track_t trk
);

    logic [HELD_W-1:0] held_reg,  held_next;
    logic              grace_reg, grace_next;
    logic              pp_reg,    pp_next;
    logic              nx_reg,    nx_next;
    logic              off_reg,   off_next;
    logic              valid_reg;
    track_t            trk_reg,   trk_next;

    logic              accept;
    logic              hold;
    logic [HELD_W:0]   sum;
    logic [HELD_W-1:0] h_new;
    logic [HELD_W:0]   reach_sum;
    logic              off_hit, next_hit, pp_hit;

    assign in_ready = !valid_reg || trk_ready;
    assign accept   = in_valid && in_ready;
    assign hold     = pad_touched || grace_reg;

    assign sum       = {1'b0, held_reg} + (HELD_W+1)'(cfg.tick_ms);
    assign h_new     = sum[HELD_W] ? '1 : sum[HELD_W-1:0];
    assign reach_sum = {1'b0, h_new} + (HELD_W+1)'(cfg.tick_ms);
    assign off_hit   = reach_sum > (HELD_W+1)'(cfg.power_off_ms);
    assign next_hit  = reach_sum > (HELD_W+1)'(cfg.next_ms);
    assign pp_hit    = reach_sum > (HELD_W+1)'(cfg.play_pause_ms);

    always_comb
    begin
        held_next  = held_reg;
        grace_next = grace_reg;
        pp_next    = pp_reg;
        nx_next    = nx_reg;
        off_next   = off_reg;
        trk_next   = '{action: ACT_NONE, mode: LED_NONE, red: 1'b0, diff: '0};
        if (hold)
        begin
            held_next  = h_new;
            grace_next = pad_touched;
            if (off_hit)
            begin
                off_next = 1'b1;
            end
            else if (next_hit)
            begin
                nx_next      = 1'b1;
                trk_next.mode = LED_RED;
                trk_next.red  = 1'b1;
                if (h_new > HELD_W'(cfg.next_ms))
                begin
                    trk_next.diff = h_new - HELD_W'(cfg.next_ms);
                end
            end
            else if (pp_hit)
            begin
                pp_next       = 1'b1;
                trk_next.mode = LED_GREEN;
                if (h_new > HELD_W'(cfg.play_pause_ms))
                begin
                    trk_next.diff = h_new - HELD_W'(cfg.play_pause_ms);
                end
            end
            else
            begin
                trk_next.mode = LED_YELLOW;
                trk_next.diff = h_new;
            end
        end
        else
        begin
            if (off_reg)
                trk_next.action = ACT_POWER_OFF;
            else if (nx_reg)
                trk_next.action = ACT_NEXT;
            else if (pp_reg)
                trk_next.action = ACT_PLAY_PAUSE;
            else if (held_reg != '0)
                trk_next.action = ACT_CLEAR;
            held_next = '0;
            pp_next   = 1'b0;
            nx_next   = 1'b0;
            off_next  = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            held_reg  <= '0;
            grace_reg <= 1'b0;
            pp_reg    <= 1'b0;
            nx_reg    <= 1'b0;
            off_reg   <= 1'b0;
            valid_reg <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                held_reg  <= held_next;
                grace_reg <= grace_next;
                pp_reg    <= pp_next;
                nx_reg    <= nx_next;
                off_reg   <= off_next;
            end
            if (in_ready)
                valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
            trk_reg <= trk_next;
    end

    assign trk_valid = valid_reg;
    assign trk       = trk_reg;

endmodule

// ===== design/thdc_bar_level.sv =====
// Loading bar level: scale by LED count, saturate, divide by 1000.
// Depends on thdc_pkg; two register stages, the second drives the outputs.
module thdc_bar_level
    import thdc_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               trk_valid,
    output logic               trk_ready,
    input  track_t             trk,
    output logic               out_valid,
    input  logic               out_ready,
    output logic [2:0]         action,
    output logic [1:0]         led_mode,
    output logic [LEVEL_W-1:0] led_level
);

    logic               scl_valid_reg;
    scaled_t            scl_reg, scl_next;
    logic               scl_ready;
    logic               out_valid_reg;
    logic               out_ready_int;
    action_t            action_reg;
    led_mode_t          mode_reg;
    logic [LEVEL_W-1:0] level_reg, level_next;

    logic [K_W-1:0]     k_sel;
    logic               sat;
    logic [QMUL_W-1:0]  qmul;

    assign out_ready_int = !out_valid_reg || out_ready;
    assign scl_ready     = !scl_valid_reg || out_ready_int;
    assign trk_ready     = scl_ready;

    // Scale the held time past the zone base by the bar's LED span
    assign k_sel           = trk.red ? K_W'(RED_K) : K_W'(GREEN_K);
    assign scl_next.action = trk.action;
    assign scl_next.mode   = trk.mode;
    assign scl_next.prod   = PROD_W'(trk.diff) * PROD_W'(k_sel);

    // Anything at or above 256 seconds-of-LEDs pins to full scale
    assign sat  = scl_reg.prod >= PROD_W'(SAT_LIMIT);
    assign qmul = QMUL_W'(scl_reg.prod[SAT_W-1:0]) * QMUL_W'(DIV_M);
    assign level_next = sat ? LEVEL_W'(LEVEL_MAX) : qmul[DIV_SHIFT +: LEVEL_W];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            scl_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (scl_ready)
                scl_valid_reg <= trk_valid;
            if (out_ready_int)
                out_valid_reg <= scl_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (trk_valid && scl_ready)
            scl_reg <= scl_next;
        if (scl_valid_reg && out_ready_int)
        begin
            action_reg <= scl_reg.action;
            mode_reg   <= scl_reg.mode;
            level_reg  <= level_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign action    = action_reg;
    assign led_mode  = mode_reg;
    assign led_level = level_reg;

endmodule

// ===== dv/thdc_tb_pkg.sv =====
// Scoreboard for the touch hold duration classifier bench: keeps its own copy
// of the hold state and registers, predicts one result per accepted tick and
// checks results in order. Depends on thdc_pkg.
package thdc_tb_pkg;
    import thdc_pkg::*;

    typedef struct {
        action_t            act;
        led_mode_t          mode;
        logic [LEVEL_W-1:0] level;
    } tick_result_t;

    localparam int unsigned HELD_MAX     = (1 << HELD_W) - 1;
    localparam int          REPORT_LIMIT = 10;

    class hold_scoreboard;
        cfg_t         cfg;
        int unsigned  held;
        bit           grace;
        bit           pp_armed;
        bit           next_armed;
        bit           off_armed;
        tick_result_t pending_results[$];
        int           mismatches;
        int           results_seen;

        function new();
            cfg.tick_ms       = TICK_RST;
            cfg.play_pause_ms = PLAY_RST;
            cfg.next_ms       = NEXT_RST;
            cfg.power_off_ms  = POWER_RST;
            held         = 0;
            grace        = 1'b0;
            pp_armed     = 1'b0;
            next_armed   = 1'b0;
            off_armed    = 1'b0;
            mismatches   = 0;
            results_seen = 0;
        endfunction

        function void set_reg(reg_idx_t idx, logic [DATA_W-1:0] value);
            case (idx)
                REG_TICK:       cfg.tick_ms       = value[TICK_W-1:0];
                REG_PLAY_PAUSE: cfg.play_pause_ms = value[THR_W-1:0];
                REG_NEXT:       cfg.next_ms       = value[THR_W-1:0];
                REG_POWER_OFF:  cfg.power_off_ms  = value[THR_W-1:0];
                default: ;
            endcase
        endfunction

        // Bar level above a zone base, clamped at zero and saturated
        function logic [LEVEL_W-1:0] bar_level(int unsigned h, int unsigned base,
                                               int unsigned k);
            longint unsigned v;
            if (h <= base)
                return '0;
            v = (longint'(h - base) * k) / MS_PER_S;
            return (v > LEVEL_MAX) ? LEVEL_W'(LEVEL_MAX) : LEVEL_W'(v);
        endfunction

        // Advance the hold state by one accepted tick and queue its result
        function void note_tick(bit touched);
            tick_result_t r;
            int unsigned  t;
            int unsigned  sum;
            r.act   = ACT_NONE;
            r.mode  = LED_NONE;
            r.level = '0;
            t = cfg.tick_ms;
            if (touched || grace) begin
                sum   = held + t;
                held  = (sum > HELD_MAX) ? HELD_MAX : sum;
                grace = touched;
                if (held + t > cfg.power_off_ms) begin
                    off_armed = 1'b1;
                end else if (held + t > cfg.next_ms) begin
                    next_armed = 1'b1;
                    r.mode     = LED_RED;
                    r.level    = bar_level(held, cfg.next_ms, RED_K);
                end else if (held + t > cfg.play_pause_ms) begin
                    pp_armed = 1'b1;
                    r.mode   = LED_GREEN;
                    r.level  = bar_level(held, cfg.play_pause_ms, GREEN_K);
                end else begin
                    r.mode  = LED_YELLOW;
                    r.level = bar_level(held, 0, GREEN_K);
                end
            end else begin
                if (off_armed)
                    r.act = ACT_POWER_OFF;
                else if (next_armed)
                    r.act = ACT_NEXT;
                else if (pp_armed)
                    r.act = ACT_PLAY_PAUSE;
                else if (held != 0)
                    r.act = ACT_CLEAR;
                held       = 0;
                pp_armed   = 1'b0;
                next_armed = 1'b0;
                off_armed  = 1'b0;
            end
            pending_results.push_back(r);
        endfunction

        function void check_result(logic [2:0] act, logic [1:0] mode,
                                   logic [LEVEL_W-1:0] level);
            tick_result_t e;
            results_seen++;
            if (pending_results.size() == 0) begin
                mismatches++;
                if (mismatches <= REPORT_LIMIT)
                    $display("result %0d unexpected: action %0d mode %0d level %0d",
                             results_seen, act, mode, level);
                return;
            end
            e = pending_results.pop_front();
            if (act !== e.act || mode !== e.mode || level !== e.level) begin
                mismatches++;
                if (mismatches <= REPORT_LIMIT)
                    $display({"result %0d: expected action %0d mode %0d level %0d, ",
                              "got action %0d mode %0d level %0d"},
                             results_seen, e.act, e.mode, e.level, act, mode, level);
            end
        endfunction

        function int pending();
            return pending_results.size();
        endfunction
    endclass

endpackage

// ===== dv/tb_top.sv =====
// Top-level bench for touch_hold_duration_classifier: drives ticks and register
// writes, stalls the result side, and checks every result against the
// scoreboard. Depends on thdc_pkg, thdc_tb_pkg and the design files.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import thdc_pkg::*;
    import thdc_tb_pkg::*;

    localparam int HALF_PERIOD    = 10;
    localparam int CYCLE_LIMIT    = 1_000_000;
    localparam int MAX_SEQ_LEN    = 60;
    localparam int THR_MAX        = (1 << THR_W) - 1;
    localparam int TICK_MAX       = (1 << TICK_W) - 1;

    logic               clk = 1'b0;
    logic               rst_n;
    logic               psel;
    logic               penable;
    logic               pwrite;
    logic [ADDR_W-1:0]  paddr;
    logic [DATA_W-1:0]  pwdata;
    logic [DATA_W-1:0]  prdata;
    logic               pready;
    logic               in_valid;
    logic               in_ready;
    logic               pad_touched;
    logic               out_valid;
    logic               out_ready;
    logic [2:0]         action;
    logic [1:0]         led_mode;
    logic [LEVEL_W-1:0] led_level;

    hold_scoreboard sb = new();

    int unsigned cycles = 0;
    bit          tx_calm = 1'b0;   // sender offers back to back while set
    int          holdoff_req = 0;  // bumped by the sender to ask for a long stall

    touch_hold_duration_classifier uut (.*);

    always #(HALF_PERIOD) clk = ~clk;

    // Sample both handshakes at the rising edge: note the accepted tick first,
    // then check the accepted result (a result never comes from the same edge).
    always @(posedge clk) begin
        if (rst_n) begin
            if (in_valid && in_ready)
                sb.note_tick(pad_touched);
            if (out_valid && out_ready)
                sb.check_result(action, led_mode, led_level);
        end
    end

    // Watchdog: end the run if it hangs anywhere
    always @(posedge clk) begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycles);
            $display("*** FAILED ***");
            $finish;
        end
    end

    // Gap length: mostly short, a few long
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 75)
            return $urandom_range(1, 3);
        else if (r < 95)
            return $urandom_range(4, 10);
        return $urandom_range(20, 40);
    endfunction

    function automatic int tx_gap();
        if (tx_calm || $urandom_range(0, 99) >= 35)
            return 0;
        return pick_gap();
    endfunction

    function automatic int clip_thr(int v);
        return (v > THR_MAX) ? THR_MAX : v;
    endfunction

    // Result side: random ready with calm stretches. A long hold-off request
    // from the sender drops ready for a random hold-off, counted down here, so the
    // pipeline backs up and in_ready falls while ticks keep coming.
    initial begin : receiver
        int low_left;
        int holdoffs_done;
        bit calm;
        low_left      = 0;
        holdoffs_done = 0;
        calm          = 1'b0;
        out_ready     = 1'b0;
        @(posedge rst_n);
        forever begin
            @(negedge clk);
            if (holdoff_req != holdoffs_done) begin
                holdoffs_done = holdoff_req;
                low_left      = $urandom_range(80, 120);
            end else if ($urandom_range(0, 299) == 0) begin
                calm = !calm;
            end
            if (low_left > 0) begin
                out_ready <= 1'b0;
                low_left--;
            end else begin
                out_ready <= 1'b1;
                if (!calm && $urandom_range(0, 99) < 30)
                    low_left = pick_gap();
            end
        end
    end

    // Offer one tick and hold it until accepted. Enter and leave at a falling
    // edge; with no gap, valid stays high so the next call just swaps payload.
    task automatic put_tick(input bit touched, input int gap);
        in_valid    <= 1'b1;
        pad_touched <= touched;
        do
            @(posedge clk);
        while (!in_ready);
        @(negedge clk);
        if (gap > 0) begin
            in_valid    <= 1'b0;
            pad_touched <= 1'($urandom_range(0, 1));
            repeat (gap) @(negedge clk);
        end
    endtask

    // Drop valid and wait until every expected result has come back, plus
    // the pipeline depth, so the block is idle.
    task automatic drain();
        in_valid <= 1'b0;
        while (sb.pending() > 0)
            @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    // APB write: setup phase, access phase, then an idle gap with psel low, so
    // that back-to-back writes never drive psel twice in one step.
    task automatic write_reg(input reg_idx_t idx, input logic [DATA_W-1:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= ADDR_W'({idx, 2'b00});
        pwdata  <= value;
        @(negedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        sb.set_reg(idx, value);
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(negedge clk);
    endtask

    task automatic configure(input int tick, input int pp, input int nx, input int off);
        drain();
        write_reg(REG_TICK, DATA_W'(tick));
        write_reg(REG_PLAY_PAUSE, DATA_W'(pp));
        write_reg(REG_NEXT, DATA_W'(nx));
        write_reg(REG_POWER_OFF, DATA_W'(off));
    endtask

    // Mostly well-formed holds (with the odd single missed tick that grace
    // covers) followed by one or two release ticks; the rest is noise.
    task automatic run_random(input int n_items);
        int done;
        int len;
        int thr;
        int max_len;
        bit prev;
        bit b;
        done = 0;
        thr  = sb.cfg.play_pause_ms;
        if (sb.cfg.next_ms > thr)
            thr = sb.cfg.next_ms;
        if (sb.cfg.power_off_ms > thr)
            thr = sb.cfg.power_off_ms;
        max_len = (sb.cfg.tick_ms == 0) ? 8 : thr / sb.cfg.tick_ms + 3;
        if (max_len > MAX_SEQ_LEN)
            max_len = MAX_SEQ_LEN;
        while (done < n_items) begin
            if ($urandom_range(0, 99) < 15) begin
                len = $urandom_range(1, 6);
                repeat (len) begin
                    put_tick(1'($urandom_range(0, 1)), tx_gap());
                    done++;
                end
            end else begin
                len  = $urandom_range(1, max_len);
                prev = 1'b0;
                for (int i = 0; i < len; i++) begin
                    b = !(prev && i < len - 1 && $urandom_range(0, 7) == 0);
                    put_tick(b, tx_gap());
                    prev = b;
                    done++;
                end
                repeat ($urandom_range(1, 2)) begin
                    put_tick(1'b0, tx_gap());
                    done++;
                end
            end
        end
    endtask

    initial begin : stimulus
        // idle release, short hold, grace ticks, then a hold that walks
        // yellow -> green (level clamped at the zone edge) -> red, and release
        bit directed_ticks[] = '{0, 1, 0, 1, 0, 1, 0, 0,
                                 1, 1, 1, 1, 1, 1, 1, 1,
                                 1, 1, 1, 1, 1, 1, 1, 1, 0};
        int t;
        int pp;
        int nx;
        int off;

        rst_n       = 1'b0;
        psel        = 1'b0;
        penable     = 1'b0;
        pwrite      = 1'b0;
        paddr       = '0;
        pwdata      = '0;
        in_valid    = 1'b0;
        pad_touched = 1'b0;
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed part under the reset values of the registers
        foreach (directed_ticks[i])
            put_tick(directed_ticks[i], tx_gap());

        // Keep offering back to back while the result side stalls long
        tx_calm = 1'b1;
        holdoff_req <= holdoff_req + 1;
        run_random(100);
        tx_calm = 1'b0;

        // Smallest nonzero tick with zero thresholds: power off on the first tick
        configure(1, 0, 0, 0);
        run_random(60);

        // Tick of 1000 ms with top thresholds: yellow level saturates at 255
        configure(1000, THR_MAX, THR_MAX, THR_MAX);
        run_random(100);

        // Tick of zero: held time never grows, zones test H > T, and every
        // release is an idle release
        configure(0, 0, 1, THR_MAX);
        run_random(40);

        // Widest tick value the register holds, with top thresholds
        configure(TICK_MAX, THR_MAX, THR_MAX, THR_MAX);
        run_random(20);

        // Random settings: mostly ordered zones a few ticks apart, sometimes
        // arbitrary (unordered) thresholds
        for (int p = 0; p < 4; p++) begin
            t = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 10)
                                             : $urandom_range(1, 1000);
            if ($urandom_range(0, 3) == 0) begin
                pp  = $urandom_range(0, THR_MAX);
                nx  = $urandom_range(0, THR_MAX);
                off = $urandom_range(0, THR_MAX);
            end else begin
                pp  = clip_thr(t * $urandom_range(0, 8) + $urandom_range(0, t));
                nx  = clip_thr(pp + t * $urandom_range(0, 8) + $urandom_range(0, t));
                off = clip_thr(nx + t * $urandom_range(1, 10) + $urandom_range(0, t));
            end
            configure(t, pp, nx, off);
            tx_calm = ($urandom_range(0, 3) == 0);
            if (p == 2)
                holdoff_req <= holdoff_req + 1;
            run_random(110);
        end
        tx_calm = 1'b0;

        drain();
        if (sb.mismatches == 0 && sb.pending() == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
